/* hw/rtl/ipmbrf_pkg.sv */
// Package for the IPMB request framer: codes, constants and item types.
`default_nettype none
package ipmbrf_pkg;

  // Framing constants
  localparam logic [7:0] FIXED_BMC_ADDR = 8'h20;
  localparam logic [7:0] SW_ID          = 8'h81;
  localparam logic [5:0] APP_NETFN      = 6'd6;
  localparam logic [7:0] SEND_MSG_CMD   = 8'h34;
  localparam logic [3:0] TRACK_REQ_NIB  = 4'h4;   // (1 << 6) in the upper channel nibble
  localparam logic [1:0] SEQ_LUN_BRIDGE = 2'd2;

  // Limits
  localparam int unsigned NUM_CHANNELS = 8;
  localparam int unsigned MAX_DATA_LEN = 255;

  // Fixed frame overhead in bytes
  localparam int unsigned DIRECT_HDR_LEN = 6;
  localparam int unsigned BRIDGE_HDR_LEN = 13;
  localparam int unsigned DIRECT_OVHD    = 7;
  localparam int unsigned BRIDGE_OVHD    = 15;

  // First header slot covered by the outer and inner checksums, and the broadcast slot
  localparam logic [3:0] OUTER_FIRST_SLOT = 4'd3;
  localparam logic [3:0] INNER_FIRST_SLOT = 4'd11;
  localparam logic [3:0] BCAST_SLOT       = 4'd7;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHANNEL_ADDRS = 2'd0;
  localparam logic [1:0] CFG_FIXED_BMC     = 2'd1;
  localparam logic [1:0] CFG_BCAST_BROKEN  = 2'd2;
  localparam logic [1:0] CFG_MAX_FRAME_LEN = 2'd3;

  localparam logic [63:0] CHANNEL_ADDRS_RST = 64'd32;
  localparam logic [8:0]  MAX_FRAME_LEN_RST = 9'd511;

  // Route kinds
  localparam logic [1:0] ROUTE_SYS   = 2'd0;
  localparam logic [1:0] ROUTE_IPMB  = 2'd1;
  localparam logic [1:0] ROUTE_BCAST = 2'd2;

  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_DATA   = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_BIG  = 2'd1,
    STAT_BAD_CHAN = 2'd2,
    STAT_NO_FRAME = 2'd3
  } status_t;

  typedef struct packed {
    logic       action;
    logic [1:0] route_kind;
    logic [3:0] channel;
    logic [7:0] dest_addr;
    logic [1:0] lun;
    logic [5:0] netfn;
    logic [7:0] cmd;
    logic [5:0] seq;
    logic [7:0] pay_len;
    logic [7:0] data_byte;
  } item_t;

endpackage
`default_nettype wire

/* hw/rtl/ipmb_request_framer.sv */
// IPMB request framer top level: input stage, byte sequencer and result register.
//
// Each accepted item is held in one input stage and stepped out one frame byte
// per cycle, while the result register is not stalled. A data item that does
// not finish a frame gives one byte, so payload streams at one byte per clock
// unless stalled. A data item that finishes a frame adds one trailing checksum
// (direct) or two (bridged). A header item gives 6 bytes (direct), 13 (bridged)
// or 14 (broadcast with the zero byte), plus the trailing checksums when the
// payload length is 0. An error result is a single byte. The next item enters in
// the cycle the last byte of the current one moves to the result register.
`default_nettype none
module ipmb_request_framer
  import ipmbrf_pkg::*;
#(
  parameter int unsigned NUM_CHAN = NUM_CHANNELS,
  parameter int unsigned MAX_LEN  = MAX_DATA_LEN
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [1:0]  in_route_kind,
  input  wire logic [3:0]  in_channel,
  input  wire logic [7:0]  in_dest_addr,
  input  wire logic [1:0]  in_lun,
  input  wire logic [5:0]  in_netfn,
  input  wire logic [7:0]  in_cmd,
  input  wire logic [5:0]  in_seq,
  input  wire logic [7:0]  in_pay_len,
  input  wire logic [7:0]  in_data_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic [1:0]       out_status
);

  // configuration registers
  logic [63:0] channel_addrs_r;
  logic        use_fixed_bmc_r;
  logic        bcast_broken_r;
  logic [8:0]  max_frame_len_r;

  // input stage
  logic        stg_vld_r;
  item_t       stg_r;
  logic [3:0]  step_r;

  // frame state
  logic        frame_open_r;
  logic        bridged_r;
  logic [7:0]  inner_sum_r;
  logic [7:0]  outer_sum_r;
  logic [7:0]  bytes_left_r;

  // result register
  logic        out_vld_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  status_t     out_status_r;

  // decode
  logic        fire;
  logic        last_step;
  logic        is_hdr;
  logic        direct;
  logic        bcast;
  logic        is_err;
  status_t     err_code;
  logic [9:0]  frame_len;
  logic        too_big;
  logic        bad_chan;
  logic        closes;
  logic        bridged_frame;
  logic [4:0]  body_len;
  logic [4:0]  trl_cnt;
  logic [4:0]  total;
  logic        in_body;
  logic [3:0]  slot;
  logic [7:0]  bmc;
  logic [7:0]  nl_byte;
  logic [7:0]  own_addr;
  logic [7:0]  hdr_byte;
  logic [7:0]  ic_byte;
  logic [7:0]  byte_nxt;
  logic        last_nxt;
  logic [7:0]  outer_base;
  logic [7:0]  inner_base;
  logic [7:0]  outer_add;
  logic [7:0]  inner_add;
  logic [7:0]  outer_sum_nxt;
  logic [7:0]  inner_sum_nxt;

  assign is_hdr   = (stg_r.action == ACT_HEADER);
  assign direct   = (stg_r.route_kind == ROUTE_SYS);
  assign bcast    = (stg_r.route_kind == ROUTE_BCAST) && !bcast_broken_r;
  assign bad_chan = !direct && ({1'b0, stg_r.channel} >= 5'(NUM_CHAN));
  assign frame_len = {2'b00, stg_r.pay_len}
                   + (direct ? 10'(DIRECT_OVHD) : 10'(BRIDGE_OVHD) + {9'd0, bcast});
  assign too_big  = ({2'b00, stg_r.pay_len} > 10'(MAX_LEN))
                 || (frame_len > {1'b0, max_frame_len_r});

  always_comb begin
    is_err   = 1'b0;
    err_code = STAT_OK;
    if (is_hdr) begin
      if (bad_chan) begin
        is_err   = 1'b1;
        err_code = STAT_BAD_CHAN;
      end else if (too_big) begin
        is_err   = 1'b1;
        err_code = STAT_TOO_BIG;
      end
    end else if (!frame_open_r) begin
      is_err   = 1'b1;
      err_code = STAT_NO_FRAME;
    end
  end

  assign bridged_frame = is_hdr ? !direct : bridged_r;
  assign closes = is_hdr ? (stg_r.pay_len == 8'd0) : (bytes_left_r == 8'd1);

  always_comb begin
    if (is_err || !is_hdr) begin
      body_len = 5'd1;
    end else if (direct) begin
      body_len = 5'(DIRECT_HDR_LEN);
    end else begin
      body_len = 5'(BRIDGE_HDR_LEN) + {4'd0, bcast};
    end
  end

  assign trl_cnt   = (is_err || !closes) ? 5'd0 : (bridged_frame ? 5'd2 : 5'd1);
  assign total     = body_len + trl_cnt;
  assign last_step = ({1'b0, step_r} == total - 5'd1);
  assign in_body   = ({1'b0, step_r} < body_len);

  // skip the broadcast slot when it is not sent
  assign slot = (direct || bcast || (step_r < BCAST_SLOT)) ? step_r : step_r + 4'd1;

  assign bmc      = use_fixed_bmc_r ? FIXED_BMC_ADDR : channel_addrs_r[7:0];
  assign nl_byte  = {stg_r.netfn, stg_r.lun};
  assign own_addr = channel_addrs_r[{stg_r.channel[2:0], 3'b000} +: 8];
  assign ic_byte  = 8'd0 - inner_sum_r;

  always_comb begin
    if (direct) begin
      case (slot)
        4'd0:    hdr_byte = bmc;
        4'd1:    hdr_byte = nl_byte;
        4'd2:    hdr_byte = 8'd0 - (bmc + nl_byte);
        4'd3:    hdr_byte = SW_ID;
        4'd4:    hdr_byte = {stg_r.seq, 2'b00};
        4'd5:    hdr_byte = stg_r.cmd;
        default: hdr_byte = 8'd0;
      endcase
    end else begin
      case (slot)
        4'd0:    hdr_byte = bmc;
        4'd1:    hdr_byte = {APP_NETFN, 2'b00};
        4'd2:    hdr_byte = 8'd0 - (bmc + {APP_NETFN, 2'b00});
        4'd3:    hdr_byte = SW_ID;
        4'd4:    hdr_byte = {stg_r.seq, 2'b00};
        4'd5:    hdr_byte = SEND_MSG_CMD;
        4'd6:    hdr_byte = {TRACK_REQ_NIB, stg_r.channel};
        4'd7:    hdr_byte = 8'd0;
        4'd8:    hdr_byte = stg_r.dest_addr;
        4'd9:    hdr_byte = nl_byte;
        4'd10:   hdr_byte = 8'd0 - (stg_r.dest_addr + nl_byte);
        4'd11:   hdr_byte = own_addr;
        4'd12:   hdr_byte = {stg_r.seq, SEQ_LUN_BRIDGE};
        4'd13:   hdr_byte = stg_r.cmd;
        default: hdr_byte = 8'd0;
      endcase
    end
  end

  // byte selection and running checksums
  always_comb begin
    byte_nxt   = 8'd0;
    last_nxt   = 1'b0;
    outer_base = outer_sum_r;
    inner_base = inner_sum_r;
    outer_add  = 8'd0;
    inner_add  = 8'd0;
    if (is_err) begin
      last_nxt = 1'b1;
    end else if (in_body) begin
      if (is_hdr) begin
        byte_nxt = hdr_byte;
        if (step_r == 4'd0) begin
          outer_base = 8'd0;
          inner_base = 8'd0;
        end
        if (slot >= OUTER_FIRST_SLOT) outer_add = hdr_byte;
        if (!direct && (slot >= INNER_FIRST_SLOT)) inner_add = hdr_byte;
      end else begin
        byte_nxt  = stg_r.data_byte;
        outer_add = stg_r.data_byte;
        inner_add = stg_r.data_byte;
      end
    end else if (bridged_frame && ({1'b0, step_r} == body_len)) begin
      byte_nxt  = ic_byte;
      outer_add = ic_byte;
    end else begin
      byte_nxt = 8'd0 - outer_sum_r;
      last_nxt = 1'b1;
    end
    outer_sum_nxt = outer_base + outer_add;
    inner_sum_nxt = inner_base + inner_add;
  end

  assign fire     = stg_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !stg_vld_r || (fire && last_step);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_addrs_r <= CHANNEL_ADDRS_RST;
      use_fixed_bmc_r <= 1'b0;
      bcast_broken_r  <= 1'b0;
      max_frame_len_r <= MAX_FRAME_LEN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CHANNEL_ADDRS: channel_addrs_r <= cfg_wdata;
        CFG_FIXED_BMC:     use_fixed_bmc_r <= cfg_wdata[0];
        CFG_BCAST_BROKEN:  bcast_broken_r  <= cfg_wdata[0];
        CFG_MAX_FRAME_LEN: max_frame_len_r <= cfg_wdata[8:0];
        default:           ;
      endcase
    end
  end

  // input stage and sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      step_r    <= 4'd0;
    end else begin
      if (in_valid && in_ready) begin
        stg_vld_r <= 1'b1;
        step_r    <= 4'd0;
      end else if (fire && last_step) begin
        stg_vld_r <= 1'b0;
        step_r    <= 4'd0;
      end else if (fire) begin
        step_r <= step_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_r.action     <= in_action;
      stg_r.route_kind <= in_route_kind;
      stg_r.channel    <= in_channel;
      stg_r.dest_addr  <= in_dest_addr;
      stg_r.lun        <= in_lun;
      stg_r.netfn      <= in_netfn;
      stg_r.cmd        <= in_cmd;
      stg_r.seq        <= in_seq;
      stg_r.pay_len    <= in_pay_len;
      stg_r.data_byte  <= in_data_byte;
    end
  end

  // frame state: sums move per byte, the rest commits on the item's last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      bridged_r    <= 1'b0;
      inner_sum_r  <= 8'd0;
      outer_sum_r  <= 8'd0;
      bytes_left_r <= 8'd0;
    end else if (fire) begin
      if (!is_err) begin
        inner_sum_r <= inner_sum_nxt;
        outer_sum_r <= outer_sum_nxt;
      end
      if (last_step) begin
        if (is_err) begin
          frame_open_r <= 1'b0;
          bytes_left_r <= 8'd0;
        end else if (is_hdr) begin
          frame_open_r <= (stg_r.pay_len != 8'd0);
          bridged_r    <= !direct;
          bytes_left_r <= stg_r.pay_len;
        end else begin
          bytes_left_r <= bytes_left_r - 8'd1;
          if (closes) frame_open_r <= 1'b0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r   <= byte_nxt;
      out_last_r   <= last_nxt;
      out_status_r <= err_code;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

`ifndef ASSERT_OFF
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r |-> ({1'b0, step_r} < total))
    else $error("sequencer step past end of item");

  a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    frame_open_r == (bytes_left_r != 8'd0))
    else $error("frame open flag and byte count disagree");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_status_r != STAT_OK)) |-> (out_last_r && (out_byte_r == 8'd0)))
    else $error("error transfer not a single last zero byte");

  a_no_advance_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r && out_vld_r && !out_ready && !last_step) |=> $stable(step_r))
    else $error("sequencer advanced while result register stalled");
`endif

endmodule
`default_nettype wire
